// ----- rtl/core/psr_pkg.sv -----
package psr_pkg;

  localparam int SENDER_W = 6;
  localparam int SEQ_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int TDATA_W  = 56;

  typedef enum logic [STATUS_W-1:0] {
    ST_DELIVERED = 2'd0,
    ST_BACKWARDS = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic {
    ALU_SUB,
    ALU_INC
  } alu_op_t;

  typedef struct packed {
    logic zero;
    logic borrow;
  } alu_flags_t;

endpackage

// ----- rtl/core/psr_ram.sv -----
module psr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/psr_alu.sv -----
module psr_alu (
  input  psr_pkg::alu_op_t           op,
  input  logic [psr_pkg::SEQ_W-1:0]  a,
  input  logic [psr_pkg::SEQ_W-1:0]  b,
  output logic [psr_pkg::SEQ_W-1:0]  res,
  output psr_pkg::alu_flags_t        flags
);

  logic [psr_pkg::SEQ_W:0] wide;

  always_comb begin
    unique case (op)
      psr_pkg::ALU_SUB: wide = {1'b0, a} - {1'b0, b};
      psr_pkg::ALU_INC: wide = {1'b0, a} + (psr_pkg::SEQ_W + 1)'(1);
      default:          wide = '0;
    endcase
    res          = wide[psr_pkg::SEQ_W-1:0];
    flags.zero   = (wide[psr_pkg::SEQ_W-1:0] == '0);
    flags.borrow = wide[psr_pkg::SEQ_W];
  end

endmodule

// ----- rtl/core/per_source_sequence_reorder.sv -----
// per-sender sequence reorder buffer
// input stream s_*: tdata carries sender, seq_num and msg_handle, tuser the bypass
// flag. one transaction is taken at a time; s_tready is low while a message is
// being worked on and while the output register holds a result that cannot leave.
// output stream m_*: tdata carries handle, sender and sequence number, tuser the
// status, tlast marks the final result caused by one input transaction.
// a bypass message is registered into the output in the cycle after acceptance.
// other messages take a lookup of the expected number and a compare in the shared
// 32-bit alu (CMP, DECIDE); a backwards or overflow result is pushed from DECIDE,
// a held message (no result) is written to its hold slot in HCHK, and an in-order
// message passes ADV (alu increment, read of the next hold slot) and WCHK per result.
// after reset the block clears the hold and expected-number memories, one entry
// a cycle, across all NUM_SENDERS*HOLD_WINDOW entries (512 by default), with s_tready low.
// when the receiver stalls, the result stays in the output register and the
// release walk waits; nothing is lost or repeated.
module per_source_sequence_reorder #(
  parameter int NUM_SENDERS = 64,
  parameter int HOLD_WINDOW = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [psr_pkg::TDATA_W-1:0]   s_tdata,  // sender, seq_num, msg_handle
  input  logic                          s_tuser,  // bypass
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [psr_pkg::TDATA_W-1:0]   m_tdata,  // out_handle, out_sender, out_seq
  output logic [psr_pkg::STATUS_W-1:0]  m_tuser,  // status
  output logic                          m_tlast   // last
);

  localparam int HDEPTH = NUM_SENDERS * HOLD_WINDOW;
  localparam int HAW    = $clog2(HDEPTH);
  localparam int RW     = $clog2(NUM_SENDERS);
  localparam int SW     = (HOLD_WINDOW > 1) ? $clog2(HOLD_WINDOW) : 1;
  localparam int DW     = $clog2(HOLD_WINDOW + 1);
  localparam int CW     = HAW + 1;
  localparam int EW     = psr_pkg::SEQ_W + SW;
  localparam int HW     = psr_pkg::HANDLE_W + 1;
  localparam int NIN    = 2 ** psr_pkg::SENDER_W;

  typedef logic [NIN-1:0][RW-1:0] row_tbl_t;

  function automatic row_tbl_t make_rows();
    row_tbl_t tbl;
    int r;
    r = 0;
    for (int i = 0; i < NIN; i++) begin
      tbl[i] = RW'(r);
      r = (r == NUM_SENDERS - 1) ? 0 : r + 1;
    end
    return tbl;
  endfunction

  localparam row_tbl_t ROW_TBL = make_rows();

  typedef enum logic [2:0] {
    CLEAR,
    IDLE,
    CMP,
    DECIDE,
    HCHK,
    ADV,
    WCHK
  } state_t;

  state_t state;
  logic [CW-1:0] clr_cnt;

  logic [psr_pkg::SEQ_W-1:0]    seq_q;
  logic [psr_pkg::HANDLE_W-1:0] handle_q;
  logic [psr_pkg::SENDER_W-1:0] sender_q;
  logic [RW-1:0]                row_q;
  logic [HAW-1:0]               row_base;
  logic [psr_pkg::SEQ_W-1:0]    exp_q;
  logic [SW-1:0]                base_q;
  logic [DW-1:0]                diff_q;
  logic                         zero_q;
  logic                         borrow_q;
  logic                         over_q;
  logic [HAW-1:0]               haddr;
  logic [psr_pkg::HANDLE_W-1:0] pend_handle;
  logic [psr_pkg::SEQ_W-1:0]    pend_seq;

  logic [psr_pkg::HANDLE_W-1:0] o_handle;
  logic [psr_pkg::SENDER_W-1:0] o_sender;
  logic [psr_pkg::SEQ_W-1:0]    o_seq;
  psr_pkg::status_t             o_status;
  logic                         o_last;

  logic [psr_pkg::SENDER_W-1:0] in_sender;
  logic [psr_pkg::SEQ_W-1:0]    in_seq;
  logic [psr_pkg::HANDLE_W-1:0] in_handle;
  logic [RW-1:0]                in_row;
  logic                         accept;
  logic                         can_push;

  logic          exp_we;
  logic [RW-1:0] exp_waddr;
  logic [EW-1:0] exp_wdata;
  logic          exp_re;
  logic [EW-1:0] exp_rdata;

  logic           hold_we;
  logic [HAW-1:0] hold_waddr;
  logic [HW-1:0]  hold_wdata;
  logic           hold_re;
  logic [HAW-1:0] hold_raddr;
  logic [HW-1:0]  hold_rdata;

  psr_pkg::alu_op_t          alu_op;
  logic [psr_pkg::SEQ_W-1:0] alu_a;
  logic [psr_pkg::SEQ_W-1:0] alu_res;
  psr_pkg::alu_flags_t       alu_flags;

  logic [SW-1:0] base_next;
  logic [DW:0]   slot_sum;
  logic [DW:0]   slot_wrap;
  logic [HAW-1:0] slot_addr;
  logic [HAW-1:0] adv_addr;
  logic           hold_path;

  logic                         push;
  logic [psr_pkg::HANDLE_W-1:0] push_handle;
  logic [psr_pkg::SEQ_W-1:0]    push_seq;
  psr_pkg::status_t             push_status;
  logic                         push_last;

  assign in_sender = s_tdata[psr_pkg::SENDER_W-1:0];
  assign in_seq    = s_tdata[psr_pkg::SENDER_W +: psr_pkg::SEQ_W];
  assign in_handle = s_tdata[psr_pkg::SENDER_W + psr_pkg::SEQ_W +: psr_pkg::HANDLE_W];
  assign in_row    = ROW_TBL[in_sender];

  assign can_push = !m_tvalid || m_tready;
  assign s_tready = (state == IDLE) && can_push;
  assign accept   = s_tvalid && s_tready;

  assign m_tdata = {2'b00, o_seq, o_sender, o_handle};
  assign m_tuser = o_status;
  assign m_tlast = o_last;

  psr_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_SENDERS)
  ) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (exp_waddr),
    .wdata (exp_wdata),
    .re    (exp_re),
    .raddr (in_row),
    .rdata (exp_rdata)
  );

  psr_ram #(
    .WIDTH (HW),
    .DEPTH (HDEPTH)
  ) u_hold_ram (
    .clk   (clk),
    .we    (hold_we),
    .waddr (hold_waddr),
    .wdata (hold_wdata),
    .re    (hold_re),
    .raddr (hold_raddr),
    .rdata (hold_rdata)
  );

  assign alu_op = (state == ADV) ? psr_pkg::ALU_INC : psr_pkg::ALU_SUB;
  assign alu_a  = (state == ADV) ? exp_q : seq_q;

  psr_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (exp_rdata[psr_pkg::SEQ_W-1:0]),
    .res   (alu_res),
    .flags (alu_flags)
  );

  // slot of a held number, counted from the slot of the expected one
  assign base_next = (base_q == SW'(HOLD_WINDOW - 1)) ? '0 : base_q + SW'(1);
  assign slot_sum  = (DW + 1)'(base_q) + {1'b0, diff_q};
  assign slot_wrap = (slot_sum >= (DW + 1)'(HOLD_WINDOW)) ?
                     slot_sum - (DW + 1)'(HOLD_WINDOW) : slot_sum;
  assign slot_addr = row_base + HAW'(slot_wrap);
  assign adv_addr  = row_base + HAW'(base_next);
  assign hold_path = (state == DECIDE) && !zero_q && !borrow_q && !over_q;

  always_comb begin
    exp_re      = accept && !s_tuser;
    exp_we      = 1'b0;
    exp_waddr   = row_q;
    exp_wdata   = {base_q, exp_q};
    hold_we     = 1'b0;
    hold_waddr  = haddr;
    hold_wdata  = '0;
    hold_re     = 1'b0;
    hold_raddr  = slot_addr;
    push        = 1'b0;
    push_handle = handle_q;
    push_seq    = seq_q;
    push_status = psr_pkg::ST_DELIVERED;
    push_last   = 1'b1;
    unique case (state)
      CLEAR: begin
        exp_we     = ({1'b0, clr_cnt} < (CW + 1)'(NUM_SENDERS));
        exp_waddr  = clr_cnt[RW-1:0];
        exp_wdata  = '0;
        hold_we    = 1'b1;
        hold_waddr = clr_cnt[HAW-1:0];
      end
      IDLE: begin
        push        = accept && s_tuser;
        push_handle = in_handle;
        push_seq    = in_seq;
      end
      CMP: begin
      end
      DECIDE: begin
        if (!zero_q && borrow_q) begin
          push        = can_push;
          push_status = psr_pkg::ST_BACKWARDS;
        end else if (!zero_q && over_q) begin
          push        = can_push;
          push_status = psr_pkg::ST_OVERFLOW;
        end else if (!zero_q) begin
          hold_re = 1'b1;
        end
      end
      HCHK: begin
        hold_we    = !hold_rdata[psr_pkg::HANDLE_W];
        hold_wdata = {1'b1, handle_q};
      end
      ADV: begin
        hold_re    = 1'b1;
        hold_raddr = adv_addr;
      end
      WCHK: begin
        push        = can_push;
        push_handle = pend_handle;
        push_seq    = pend_seq;
        push_last   = !hold_rdata[psr_pkg::HANDLE_W];
        hold_we     = can_push && hold_rdata[psr_pkg::HANDLE_W];
        exp_we      = can_push && !hold_rdata[psr_pkg::HANDLE_W];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (push) begin
        m_tvalid <= 1'b1;
        o_handle <= push_handle;
        o_sender <= (state == IDLE) ? in_sender : sender_q;
        o_seq    <= push_seq;
        o_status <= push_status;
        o_last   <= push_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        CLEAR: begin
          clr_cnt <= clr_cnt + CW'(1);
          if (clr_cnt == CW'(HDEPTH - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (accept) begin
            seq_q    <= in_seq;
            handle_q <= in_handle;
            sender_q <= in_sender;
            row_q    <= in_row;
            if (!s_tuser) begin
              state <= CMP;
            end
          end
        end
        CMP: begin
          exp_q    <= exp_rdata[psr_pkg::SEQ_W-1:0];
          base_q   <= exp_rdata[psr_pkg::SEQ_W +: SW];
          diff_q   <= alu_res[DW-1:0];
          zero_q   <= alu_flags.zero;
          borrow_q <= alu_flags.borrow;
          over_q   <= (alu_res > psr_pkg::SEQ_W'(HOLD_WINDOW));
          row_base <= HAW'(row_q) * HAW'(HOLD_WINDOW);
          state    <= DECIDE;
        end
        DECIDE: begin
          if (zero_q) begin
            pend_handle <= handle_q;
            pend_seq    <= seq_q;
            state       <= ADV;
          end else if (borrow_q || over_q) begin
            if (can_push) begin
              state <= IDLE;
            end
          end else begin
            haddr <= slot_addr;
            state <= HCHK;
          end
        end
        HCHK: begin
          state <= IDLE;
        end
        ADV: begin
          exp_q  <= alu_res;
          base_q <= base_next;
          haddr  <= adv_addr;
          state  <= WCHK;
        end
        WCHK: begin
          if (can_push) begin
            if (hold_rdata[psr_pkg::HANDLE_W]) begin
              pend_handle <= hold_rdata[psr_pkg::HANDLE_W-1:0];
              pend_seq    <= exp_q;
              state       <= ADV;
            end else begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (!m_tvalid || m_tready))
    else $error("result overwrites a pending transaction");

  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    (accept && !s_tuser) |=> (state == CMP))
    else $error("ordered message did not start its lookup");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    hold_path |-> (slot_wrap < (DW + 1)'(HOLD_WINDOW)))
    else $error("hold slot outside the sender window");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == CLEAR) |-> (!s_tready && !push))
    else $error("traffic during memory clearing");
`endif

endmodule

// ----- sim/tb_per_source_sequence_reorder.sv -----
module tb_per_source_sequence_reorder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SENDERS = 64;
  localparam int HOLD_WINDOW = 8;
  localparam int LONG_STALL  = 300;
  localparam int DRAIN       = 40;
  localparam int LIMIT       = 200000;

  typedef struct {
    logic [psr_pkg::HANDLE_W-1:0] handle;
    logic [psr_pkg::SENDER_W-1:0] sender;
    logic [psr_pkg::SEQ_W-1:0]    seq;
    psr_pkg::status_t             status;
    logic                         last;
  } delivery_t;

  class reorder_scoreboard;
    logic [psr_pkg::SEQ_W-1:0]    next_seq [NUM_SENDERS];
    bit                           held [NUM_SENDERS*HOLD_WINDOW];
    logic [psr_pkg::HANDLE_W-1:0] held_handle [NUM_SENDERS*HOLD_WINDOW];
    delivery_t                    due_q [$];
    int                           errors;

    function new();
      foreach (next_seq[i]) next_seq[i] = '0;
      foreach (held[i]) held[i] = 1'b0;
      errors = 0;
    endfunction

    function void add(logic [psr_pkg::HANDLE_W-1:0] handle,
                      logic [psr_pkg::SENDER_W-1:0] sender,
                      logic [psr_pkg::SEQ_W-1:0] seq, psr_pkg::status_t status);
      delivery_t d;
      d.handle = handle;
      d.sender = sender;
      d.seq    = seq;
      d.status = status;
      d.last   = 1'b0;
      due_q.insert(due_q.size(), d);
    endfunction

    // work out the results caused by one accepted message
    function void note_arrival(logic [psr_pkg::SENDER_W-1:0] sender,
                               logic [psr_pkg::SEQ_W-1:0] seq,
                               logic [psr_pkg::HANDLE_W-1:0] handle, logic bypass);
      int first;
      int row;
      int slot;
      logic [psr_pkg::SEQ_W-1:0] nxt;
      first = due_q.size();
      row   = sender % NUM_SENDERS;
      nxt   = next_seq[row];
      if (bypass) begin
        add(handle, sender, seq, psr_pkg::ST_DELIVERED);
      end else if (seq == nxt) begin
        add(handle, sender, seq, psr_pkg::ST_DELIVERED);
        nxt  = nxt + 1;
        slot = row * HOLD_WINDOW + int'(nxt % HOLD_WINDOW);
        while (held[slot]) begin
          add(held_handle[slot], sender, nxt, psr_pkg::ST_DELIVERED);
          held[slot] = 1'b0;
          nxt  = nxt + 1;
          slot = row * HOLD_WINDOW + int'(nxt % HOLD_WINDOW);
        end
        next_seq[row] = nxt;
      end else if (seq < nxt) begin
        add(handle, sender, seq, psr_pkg::ST_BACKWARDS);
      end else if (32'(seq - nxt) > 32'(HOLD_WINDOW)) begin
        add(handle, sender, seq, psr_pkg::ST_OVERFLOW);
      end else begin
        slot = row * HOLD_WINDOW + int'(seq % HOLD_WINDOW);
        if (!held[slot]) begin
          held[slot]        = 1'b1;
          held_handle[slot] = handle;
        end
      end
      if (due_q.size() > first) due_q[$].last = 1'b1;
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_delivery(logic [psr_pkg::TDATA_W-1:0] tdata,
                                 logic [psr_pkg::STATUS_W-1:0] tuser, logic tlast);
      delivery_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, got tdata %h status %0d last %0d",
                 $time, tdata, tuser, tlast);
        return;
      end
      want = due_q.pop_front();
      if (tdata[15:0] !== want.handle) report("handle", want.handle, tdata[15:0]);
      if (tdata[21:16] !== want.sender) report("sender", want.sender, tdata[21:16]);
      if (tdata[53:22] !== want.seq) report("seq", want.seq, tdata[53:22]);
      if (tdata[55:54] !== 2'b00) report("padding", 0, tdata[55:54]);
      if (tuser !== want.status) report("status", want.status, tuser);
      if (tlast !== want.last) report("last", want.last, tlast);
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [psr_pkg::TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [psr_pkg::TDATA_W-1:0] m_tdata;
  logic [psr_pkg::STATUS_W-1:0] m_tuser;
  logic m_tlast;

  reorder_scoreboard sb = new();
  bit calm = 1'b0;
  bit stall_req = 1'b0;
  int sent_count = 0;
  int cycles = 0;

  always #1 clk = ~clk;

  per_source_sequence_reorder #(
    .NUM_SENDERS(NUM_SENDERS),
    .HOLD_WINDOW(HOLD_WINDOW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_delivery(m_tdata, m_tuser, m_tlast);
  end

  // receiver: random hold-off per transaction, one long hold-off on request
  initial begin : receiver
    int hold;
    bit took;
    hold = 0;
    forever begin
      @(posedge clk);
      took = m_tvalid && m_tready && !rst;
      @(negedge clk);
      if (rst) begin
        hold = 0;
      end else if (stall_req) begin
        stall_req = 1'b0;
        hold = LONG_STALL;
      end else if (took) begin
        hold = calm ? 0 : $urandom_range(0, 12);
      end else if (hold > 0) begin
        hold--;
      end
      m_tready = !rst && (hold == 0);
    end
  end

  task automatic offer_message(input logic [psr_pkg::SENDER_W-1:0] sender,
                               input logic [psr_pkg::SEQ_W-1:0] seq,
                               input logic [psr_pkg::HANDLE_W-1:0] handle,
                               input logic bypass);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {2'b00, handle, seq, sender};
    s_tuser  = bypass;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_arrival(sender, seq, handle, bypass);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    s_tvalid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  // a shuffled run of consecutive numbers starting at the sender's next one, with occasional repeats
  task automatic send_run(input logic [psr_pkg::SENDER_W-1:0] sender);
    logic [psr_pkg::SEQ_W-1:0] seqs [HOLD_WINDOW+1];
    logic [psr_pkg::SEQ_W-1:0] t;
    int k;
    int j;
    k = $urandom_range(1, HOLD_WINDOW + 1);
    for (int i = 0; i < k; i++) seqs[i] = sb.next_seq[sender] + i;
    for (int i = k - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = seqs[i];
      seqs[i] = seqs[j];
      seqs[j] = t;
    end
    for (int i = 0; i < k; i++) begin
      offer_message(sender, seqs[i], 16'($urandom_range(0, 65535)), 1'b0);
      if ($urandom_range(0, 7) == 0)
        offer_message(sender, seqs[$urandom_range(0, i)], 16'($urandom_range(0, 65535)), 1'b0);
    end
  endtask

  task automatic random_message();
    logic [psr_pkg::SENDER_W-1:0] sender;
    logic [psr_pkg::SEQ_W-1:0] nxt;
    sender = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
    nxt = sb.next_seq[sender];
    case ($urandom_range(0, 9))
      7: begin
        offer_message(sender, $urandom(), 16'($urandom_range(0, 65535)), 1'b1);
      end
      8: begin
        if (nxt > 0)
          offer_message(sender, $urandom_range(0, nxt - 1), 16'($urandom_range(0, 65535)), 1'b0);
        else
          offer_message(sender, $urandom(), 16'($urandom_range(0, 65535)), 1'b0);
      end
      9: begin
        offer_message(sender, nxt + HOLD_WINDOW + 1 + $urandom_range(0, 1000),
                      16'($urandom_range(0, 65535)), 1'b0);
      end
      default: begin
        send_run(sender);
      end
    endcase
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // bypass extremes, in order, held, duplicate, backwards, beyond window
    offer_message(6'd63, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    offer_message(6'd0, 32'h0, 16'h0, 1'b1);
    offer_message(6'd0, 32'd0, 16'h1234, 1'b0);
    offer_message(6'd0, 32'd3, 16'h0003, 1'b0);
    offer_message(6'd0, 32'd3, 16'hDEAD, 1'b0);
    offer_message(6'd0, 32'd2, 16'h0002, 1'b0);
    offer_message(6'd0, 32'd9, 16'h0009, 1'b0);
    offer_message(6'd0, 32'd10, 16'h000A, 1'b0);
    offer_message(6'd0, 32'd0, 16'hBEEF, 1'b0);
    offer_message(6'd0, 32'd1, 16'h0001, 1'b0);
    for (int s = 8; s >= 4; s--) offer_message(6'd0, s, 16'(16'h0100 + s), 1'b0);
    // full window then its head: longest release
    for (int s = 1; s <= HOLD_WINDOW; s++) offer_message(6'd5, s, 16'(16'hF000 + s), 1'b0);
    offer_message(6'd5, 32'd0, 16'hF000, 1'b0);
    offer_message(6'd63, 32'hFFFF_FFFF, 16'h8000, 1'b0);
    wait_quiet();

    while (sent_count < 85) random_message();
    wait_quiet();

    calm = 1'b1;
    while (sent_count < 115) random_message();

    // receiver held off while the sender keeps offering
    stall_req = 1'b1;
    for (int i = 0; i < 4; i++) send_run(6'($urandom_range(8, 15)));
    calm = 1'b0;
    wait_quiet();

    while (sent_count < 165) random_message();
    s_tvalid = 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/psr_pkg.sv
rtl/core/psr_ram.sv
rtl/core/psr_alu.sv
rtl/core/per_source_sequence_reorder.sv
sim/tb_per_source_sequence_reorder.sv
